// File: rtl/b64lw_pkg.sv
`timescale 1ns / 1ps

package b64lw_pkg;

  localparam int unsigned WordW = 24;

  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] PadChar     = 8'h3D;

  // character slots of one group, newline slot first
  localparam logic [2:0] SlotNewline = 3'd0;
  localparam logic [2:0] SlotFirst   = 3'd1;
  localparam logic [2:0] SlotSecond  = 3'd2;
  localparam logic [2:0] SlotThird   = 3'd3;
  localparam logic [2:0] SlotFourth  = 3'd4;

  // held byte counts
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldOne  = 2'd1;
  localparam logic [1:0] HeldTwo  = 2'd2;

  // one completed group of up to three bytes
  typedef struct packed {
    logic [WordW-1:0] word;     // first byte in bits 23:16
    logic [1:0]       nbytes;   // 1..3
    logic             newline;  // emit newline before the group
    logic             last;     // group ends the message
  } grp_t;

  // standard alphabet A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// File: rtl/b64lw_packer.sv
`timescale 1ns / 1ps

module b64lw_packer #(
  parameter int unsigned LINE_CHARS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wrap_enable_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 grp_valid_o,
  output b64lw_pkg::grp_t      grp_o,
  input  logic                 grp_take_i
);

  localparam int unsigned GroupsPerLine = (LINE_CHARS / 4 > 0) ? LINE_CHARS / 4 : 1;
  localparam int unsigned GilW = (GroupsPerLine > 1) ? $clog2(GroupsPerLine) : 1;
  localparam logic [GilW-1:0] GilMax = GilW'(GroupsPerLine - 1);

  logic [15:0]     held_q, held_d;
  logic [1:0]      count_q, count_d;
  logic [GilW-1:0] gil_q, gil_d;
  logic            full_q, full_d;
  b64lw_pkg::grp_t grp_q, grp_d;
  logic            accept, complete;

  assign in_ready_o  = !full_q || grp_take_i;
  assign accept      = in_valid_i && in_ready_o;
  assign complete    = in_last_i || (count_q == b64lw_pkg::HeldTwo);
  assign grp_valid_o = full_q;
  assign grp_o       = grp_q;

  always_comb begin
    held_d  = held_q;
    count_d = count_q;
    gil_d   = gil_q;
    grp_d   = grp_q;
    full_d  = full_q && !grp_take_i;
    if (accept && !complete) begin
      held_d  = {held_q[7:0], in_byte_i};
      count_d = count_q + 2'd1;
    end else if (accept) begin
      unique case (count_q)
        b64lw_pkg::HeldTwo: grp_d.word = {held_q, in_byte_i};
        b64lw_pkg::HeldOne: grp_d.word = {held_q[7:0], in_byte_i, 8'h00};
        default:            grp_d.word = {in_byte_i, 16'h0000};
      endcase
      grp_d.nbytes  = count_q + 2'd1;
      grp_d.newline = wrap_enable_i && (gil_q == '0);
      grp_d.last    = in_last_i;
      if (in_last_i || gil_q == GilMax) begin
        gil_d = '0;
      end else begin
        gil_d = gil_q + GilW'(1);
      end
      held_d  = '0;
      count_d = b64lw_pkg::HeldNone;
      full_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      count_q <= b64lw_pkg::HeldNone;
      gil_q   <= '0;
      full_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      count_q <= count_d;
      gil_q   <= gil_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

endmodule

// File: rtl/b64lw_serializer.sv
`timescale 1ns / 1ps

module b64lw_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            grp_valid_i,
  input  b64lw_pkg::grp_t grp_i,
  output logic            grp_take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);

  logic            busy_q, busy_d;
  logic [2:0]      slot_q, slot_d;
  b64lw_pkg::grp_t cur_q, cur_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      ochar_q, ochar_d;
  logic            olast_q, olast_d;
  logic            advance;
  logic [7:0]      slot_char;

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

  // output register can take a new beat
  assign advance = !ovalid_q || out_ready_i;

  // next group loads when the current one empties or nothing is in flight
  assign grp_take_o = grp_valid_i &&
                      (!busy_q || (advance && slot_q == b64lw_pkg::SlotFourth));

  always_comb begin
    unique case (slot_q)
      b64lw_pkg::SlotNewline: slot_char = b64lw_pkg::NewlineChar;
      b64lw_pkg::SlotFirst:   slot_char = b64lw_pkg::b64_char(cur_q.word[23:18]);
      b64lw_pkg::SlotSecond:  slot_char = b64lw_pkg::b64_char(cur_q.word[17:12]);
      b64lw_pkg::SlotThird:   slot_char = (cur_q.nbytes >= 2'd2) ?
                                b64lw_pkg::b64_char(cur_q.word[11:6]) : b64lw_pkg::PadChar;
      default:                slot_char = (cur_q.nbytes == 2'd3) ?
                                b64lw_pkg::b64_char(cur_q.word[5:0]) : b64lw_pkg::PadChar;
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    slot_d   = slot_q;
    cur_d    = cur_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (busy_q && advance) begin
      ovalid_d = 1'b1;
      ochar_d  = slot_char;
      olast_d  = cur_q.last && (slot_q == b64lw_pkg::SlotFourth);
      if (slot_q == b64lw_pkg::SlotFourth) begin
        busy_d = 1'b0;
      end else begin
        slot_d = slot_q + 3'd1;
      end
    end
    if (grp_take_o) begin
      busy_d = 1'b1;
      cur_d  = grp_i;
      slot_d = grp_i.newline ? b64lw_pkg::SlotNewline : b64lw_pkg::SlotFirst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      slot_q   <= b64lw_pkg::SlotFirst;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      slot_q   <= slot_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

endmodule

// File: rtl/base64_encoder_line_wrap.sv
`timescale 1ns / 1ps

// Streaming base64 encoder with optional line wrapping. Raw message bytes enter
// one per beat on the slave stream, tlast marking the final byte. Every third
// byte completes a group that leaves as four characters of the standard
// alphabet on the master stream, one character per beat; the final byte
// flushes a partial group padded with '=' and carries tlast on its last
// character. With wrap_enable set, a newline (0x0A) precedes every group that
// opens a line of LINE_CHARS characters, including the first group of each
// message; newlines never carry tlast. A byte is taken whenever
// the one-group holding slot is free or is being emptied in that cycle; while
// a closed group waits in the slot, every input byte stalls. The output side
// drains one character per cycle while m_axis_tready allows it; a group
// leaves as four characters, five with a newline. wrap_enable must only
// change while the block is idle.
module base64_encoder_line_wrap #(
  parameter int unsigned LINE_CHARS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       wrap_enable_we_i,
  input  logic       wrap_enable_i,
  // byte input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  // character output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // last_char
);

  logic            wrap_q;
  logic            grp_valid;
  logic            grp_take;
  b64lw_pkg::grp_t grp;

  // wrap mode register, sampled as each group closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
    end else if (wrap_enable_we_i) begin
      wrap_q <= wrap_enable_i;
    end
  end

  // byte gathering, line position and group holding slot
  b64lw_packer #(
    .LINE_CHARS (LINE_CHARS)
  ) u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wrap_enable_i (wrap_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .grp_valid_o   (grp_valid),
    .grp_o         (grp),
    .grp_take_i    (grp_take)
  );

  // character mapping and output register, one beat per cycle while the receiver is ready
  b64lw_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .grp_take_o  (grp_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LineChars  = 64;
  localparam int unsigned LineGroups = LineChars / 4;
  localparam int          ClkHalf    = 4;
  localparam int          CycleLimit = 200000;
  localparam int          DrainWait  = 12;   // a group with newline leaves as five characters
  localparam int          PhaseBytes = 60;
  localparam int          NumPhases  = 6;
  localparam int          MaxPrinted = 40;

  // one expected character beat on the output stream
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  // running base64 encoder with line wrapping, fed with accepted input beats
  class b64_scoreboard;
    string        alphabet;
    logic         wrap_on;
    logic [15:0]  held;
    logic [1:0]   held_cnt;
    int unsigned  line_groups;
    char_beat_t   pending[$];
    int           errors;
    int           bytes_seen;
    int           msgs_seen;
    int           chars_checked;
    int           newlines_seen;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      wrap_on = 1'b0;
      held = '0;
      held_cnt = b64lw_pkg::HeldNone;
      line_groups = 0;
      errors = 0;
      bytes_seen = 0;
      msgs_seen = 0;
      chars_checked = 0;
      newlines_seen = 0;
    endfunction

    function void set_wrap(logic w);
      wrap_on = w;
    endfunction

    function logic [7:0] digit(logic [5:0] v);
      return alphabet[v];
    endfunction

    function void push_char(logic [7:0] c, logic l);
      char_beat_t b;
      b.ch = c;
      b.last = l;
      pending.push_back(b);
    endfunction

    // an accepted raw byte: hold it, or close a group and queue its characters
    function void note_byte(logic [7:0] b, logic l);
      logic [23:0] w;
      int unsigned n;
      bytes_seen++;
      if (l) msgs_seen++;
      if (!l && held_cnt != b64lw_pkg::HeldTwo) begin
        held = {held[7:0], b};
        held_cnt = held_cnt + 2'd1;
        return;
      end
      case (held_cnt)
        b64lw_pkg::HeldTwo: begin
          w = {held, b};
          n = 3;
        end
        b64lw_pkg::HeldOne: begin
          w = {held[7:0], b, 8'h00};
          n = 2;
        end
        default: begin
          w = {b, 16'h0000};
          n = 1;
        end
      endcase
      // newline opens each line, first group of a message too
      if (wrap_on && line_groups == 0) begin
        push_char(b64lw_pkg::NewlineChar, 1'b0);
        newlines_seen++;
      end
      push_char(digit(w[23:18]), 1'b0);
      push_char(digit(w[17:12]), 1'b0);
      push_char((n >= 2) ? digit(w[11:6]) : b64lw_pkg::PadChar, 1'b0);
      push_char((n == 3) ? digit(w[5:0]) : b64lw_pkg::PadChar, l);
      line_groups = (line_groups + 1) % LineGroups;
      held = '0;
      held_cnt = b64lw_pkg::HeldNone;
      if (l) line_groups = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("mismatch: %s", msg);
    endtask

    // an accepted output beat against the oldest expected character
    task check_char(logic [7:0] c, logic l);
      char_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last=%0b", c, l));
        return;
      end
      e = pending.pop_front();
      chars_checked++;
      if (c !== e.ch)
        report($sformatf("char %0d: got 0x%02h, want 0x%02h", chars_checked, c, e.ch));
      if (l !== e.last)
        report($sformatf("char %0d: tlast got %0b, want %0b", chars_checked, l, e.last));
    endtask
  endclass

  // clock, reset and block ports
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       wrap_enable_we_i = 1'b0;
  logic       wrap_enable_i = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;   // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_char
  logic       m_axis_tlast;          // last_char

  b64_scoreboard sb = new();

  int src_idle_pct = 0;   // chance per beat that the sender holds off
  int snk_idle_pct = 0;   // chance per cycle that the receiver stalls
  int msg_left = 0;       // bytes still to go in the current random message
  int cycle_count = 0;

  base64_encoder_line_wrap #(
    .LINE_CHARS(LineChars)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wrap_enable_we_i(wrap_enable_we_i),
    .wrap_enable_i   (wrap_enable_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast)
  );

  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d chars outstanding", cycle_count,
               sb.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls on the character stream
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // monitors sample pre-edge values, so both beats of one edge are seen consistently
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // one byte beat; tvalid stays high across back-to-back beats
  task send_byte(input logic [7:0] d, input logic l);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sender goes quiet until every expected character is out, then lets the block settle
  task drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // register write, only ever done with the block drained
  task write_wrap(input logic w);
    wrap_enable_we_i <= 1'b1;
    wrap_enable_i    <= w;
    @(posedge clk_i);
    wrap_enable_we_i <= 1'b0;
    sb.set_wrap(w);
  endtask

  task send_msg(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // random messages: mostly short, some long enough to cross a line boundary;
  // a message may run on into the next phase
  task send_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (msg_left == 0)
        msg_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(44, 70);
      send_byte(8'($urandom_range(0, 255)), msg_left == 1);
      msg_left--;
    end
  endtask

  task set_idle(input int mode);
    case (mode)
      0: begin
        src_idle_pct = 35;
        snk_idle_pct = 63;
      end
      1: begin
        src_idle_pct = 63;
        snk_idle_pct = 35;
      end
      default: begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    set_idle(2);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, wrapping on: each message opens with a newline
    write_wrap(1'b1);
    send_msg('{8'h00});                      // one byte, two pads
    send_msg('{8'hFF, 8'hFF});               // two bytes, one pad
    send_msg('{8'hFB, 8'hEF, 8'hBE});        // full group of '+'
    send_msg('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80});
    drain();

    // wrapping off, and toggled back on while a byte is still held
    write_wrap(1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h01, 1'b0);
    drain();
    write_wrap(1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hA5, 1'b1);
    drain();
    write_wrap(1'b0);
    send_msg('{8'h5A, 8'h00});
    drain();

    // random phases: three idling modes, wrap setting alternating per phase
    for (int p = 0; p < NumPhases; p++) begin
      set_idle(p / 2);
      write_wrap((p % 2) == 0);
      send_random(PhaseBytes);
      drain();
    end

    $display("encoded %0d bytes over %0d complete messages, wrap off and on,",
             sb.bytes_seen, sb.msgs_seen);
    $display("checked %0d characters including %0d newlines under three stall mixes",
             sb.chars_checked, sb.newlines_seen);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d characters never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/b64lw_pkg.sv
rtl/b64lw_packer.sv
rtl/b64lw_serializer.sv
rtl/base64_encoder_line_wrap.sv
tb/tb_top.sv
